### sv/append_only_key_value_table_top_defines.svh
// ----------------------------------------------------------------------------
// append_only_key_value_table_top_defines
// assertion macros used by the checker file of the key/value table
// ----------------------------------------------------------------------------
`ifndef APPEND_ONLY_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define APPEND_ONLY_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// clocked property, switched off while reset is asserted
`define AOKVT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds during reset
`define AOKVT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/aokvt_pkg.sv
// ----------------------------------------------------------------------------
// aokvt_pkg
// shared field widths and result codes of the key/value table
// ----------------------------------------------------------------------------
`default_nettype none

package aokvt_pkg;

	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int ENTRY_IDX_W = 4;
	localparam int ENTRY_CNT_W = 5;

	// request modes
	localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WALK = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_SET_STORED = 3'd0,
		STAT_SET_FULL   = 3'd1,
		STAT_GET_HIT    = 3'd2,
		STAT_GET_MISS   = 3'd3,
		STAT_WALK_ENTRY = 3'd4
	} status_t;

endpackage

`default_nettype wire

### sv/aokvt_ram.sv
// ----------------------------------------------------------------------------
// aokvt_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aokvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/aokvt_ctrl.sv
// ----------------------------------------------------------------------------
// aokvt_ctrl
// request sequencer: linear key scan, write-back, walk and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module aokvt_ctrl #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request side
	input  wire logic                                start,
	input  wire logic [aokvt_pkg::MODE_W-1:0]        mode,
	input  wire logic [KEY_BITS-1:0]                 key,
	input  wire logic [VALUE_BITS-1:0]               value,
	output logic                                     busy,
	// result side
	output logic                                     done,
	output logic      [aokvt_pkg::STATUS_W-1:0]      status,
	output logic      [VALUE_BITS-1:0]               found_value,
	output logic      [aokvt_pkg::ENTRY_IDX_W-1:0]   entry_index,
	output logic      [aokvt_pkg::ENTRY_CNT_W-1:0]   entry_count,
	output logic                                     last,
	// memory ports
	output logic      [$clog2(CAPACITY)-1:0]         mem_raddr,
	output logic      [$clog2(CAPACITY)-1:0]         mem_waddr,
	output logic                                     key_we,
	output logic      [KEY_BITS-1:0]                 key_wdata,
	input  wire logic [KEY_BITS-1:0]                 key_rdata,
	output logic                                     value_we,
	output logic      [VALUE_BITS-1:0]               value_wdata,
	input  wire logic [VALUE_BITS-1:0]               value_rdata
);

	import aokvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WALK
	} state_t;

	state_t          state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic            vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic            set_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic                  done_q;
	status_t               status_q;
	logic [VALUE_BITS-1:0] found_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  last_q;

	logic issue;
	logic hit;
	logic scan_end;
	logic full;
	logic walk_last;
	logic scan_done;

	always_comb begin
		issue     = ptr_q < count_q;
		hit       = vld_s1 && (key_rdata == key_q);
		scan_end  = hit || (!issue && !vld_s1);
		full      = count_q == CNT_W'(CAPACITY);
		walk_last = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;
		scan_done = (state_q == S_SCAN) && scan_end;
		key_we    = scan_done && set_q && !hit && !full;
		value_we  = scan_done && set_q && (hit || !full);
		mem_waddr = hit ? idx_s1 : count_q[IDX_W-1:0];
		mem_raddr = ptr_q[IDX_W-1:0];
	end

	assign key_wdata   = key_q;
	assign value_wdata = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						vld_s1  <= 1'b0;
						set_q   <= mode == MODE_SET;
						key_q   <= key;
						value_q <= value;
						case (mode)
							MODE_SET, MODE_GET: state_q <= S_SCAN;
							MODE_WALK: begin
								if (count_q != '0) begin
									state_q <= S_WALK;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						done_q  <= 1'b1;
						last_q  <= 1'b1;
						vld_s1  <= 1'b0;
						state_q <= S_IDLE;
						if (set_q) begin
							found_q <= '0;
							if (hit) begin
								status_q <= STAT_SET_STORED;
								idx_q    <= idx_s1;
							end else if (full) begin
								status_q <= STAT_SET_FULL;
								idx_q    <= '0;
							end else begin
								status_q <= STAT_SET_STORED;
								idx_q    <= count_q[IDX_W-1:0];
								count_q  <= count_q + CNT_W'(1);
							end
						end else if (hit) begin
							status_q <= STAT_GET_HIT;
							found_q  <= value_rdata;
							idx_q    <= idx_s1;
						end else begin
							status_q <= STAT_GET_MISS;
							found_q  <= '0;
							idx_q    <= '0;
						end
					end else begin
						if (issue) begin
							ptr_q <= ptr_q + CNT_W'(1);
						end
						vld_s1 <= issue;
						idx_s1 <= ptr_q[IDX_W-1:0];
					end
				end
				S_WALK: begin
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					vld_s1 <= issue;
					idx_s1 <= ptr_q[IDX_W-1:0];
					if (vld_s1) begin
						done_q   <= 1'b1;
						status_q <= STAT_WALK_ENTRY;
						found_q  <= value_rdata;
						idx_q    <= idx_s1;
						last_q   <= walk_last;
						if (walk_last) begin
							vld_s1  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign entry_index = ENTRY_IDX_W'(idx_q);
	assign entry_count = ENTRY_CNT_W'(count_q);
	assign last        = last_q;

endmodule

`default_nettype wire

### sv/append_only_key_value_table_top.sv
// ----------------------------------------------------------------------------
// append_only_key_value_table_top
// append-only associative table of key/value pairs with linear search
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. set and get scan the
// occupied entries one per cycle through the key ram, at most 16 at the default
// capacity, and a hit ends the scan early; busy falls as the result goes out,
// so the next request can be taken in the cycle of the strobe. a walk gives one
// result per occupied entry on consecutive cycles; a walk on an empty table and
// the unused mode give no result and leave busy low. results are shown for
// exactly one cycle with done high, and the receiver cannot stall them.
// entry_count reports the occupancy after the request.
// ----------------------------------------------------------------------------
`default_nettype none

module append_only_key_value_table_top #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request
	input  wire logic                               start,
	input  wire logic [aokvt_pkg::MODE_W-1:0]       mode,
	input  wire logic [KEY_BITS-1:0]                key,
	input  wire logic [VALUE_BITS-1:0]              value,
	output logic                                    busy,
	// result, one cycle per strobe
	output logic                                    done,
	output logic      [aokvt_pkg::STATUS_W-1:0]     status,
	output logic      [VALUE_BITS-1:0]              found_value,
	output logic      [aokvt_pkg::ENTRY_IDX_W-1:0]  entry_index,
	output logic      [aokvt_pkg::ENTRY_CNT_W-1:0]  entry_count,
	output logic                                    last
);

	import aokvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	// shared read address: keys and values of one entry are read together so
	// that a get hit has its value ready in the cycle of the key compare
	logic [IDX_W-1:0]      mem_raddr;
	logic [IDX_W-1:0]      mem_waddr;
	logic                  key_we;
	logic [KEY_BITS-1:0]   key_wdata;
	logic [KEY_BITS-1:0]   key_rdata;
	logic                  value_we;
	logic [VALUE_BITS-1:0] value_wdata;
	logic [VALUE_BITS-1:0] value_rdata;

	// sequencer: scan, decide, write back, emit
	aokvt_ctrl #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.entry_index (entry_index),
		.entry_count (entry_count),
		.last        (last),
		.mem_raddr   (mem_raddr),
		.mem_waddr   (mem_waddr),
		.key_we      (key_we),
		.key_wdata   (key_wdata),
		.key_rdata   (key_rdata),
		.value_we    (value_we),
		.value_wdata (value_wdata),
		.value_rdata (value_rdata)
	);

	// key storage, only entries below the occupancy count are ever compared
	aokvt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (mem_waddr),
		.wdata (key_wdata),
		.raddr (mem_raddr),
		.rdata (key_rdata)
	);

	// value storage, rewritten on a set hit or filled on an append
	aokvt_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (value_we),
		.waddr (mem_waddr),
		.wdata (value_wdata),
		.raddr (mem_raddr),
		.rdata (value_rdata)
	);

endmodule

`default_nettype wire

### sv/aokvt_chk.sv
// ----------------------------------------------------------------------------
// aokvt_chk
// port-level checks on the result stream of the key/value table
// ----------------------------------------------------------------------------
`default_nettype none
`include "append_only_key_value_table_top_defines.svh"

module aokvt_chk #(
	parameter int VALUE_BITS = 64
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [aokvt_pkg::STATUS_W-1:0]    status,
	input wire logic [VALUE_BITS-1:0]             found_value,
	input wire logic [aokvt_pkg::ENTRY_IDX_W-1:0] entry_index,
	input wire logic [aokvt_pkg::ENTRY_CNT_W-1:0] entry_count,
	input wire logic                              last
);

	import aokvt_pkg::*;

	// strobe register is cleared by the reset, so it reads low from the next edge on
	`AOKVT_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |=> !done, "result strobe after reset")

	`AOKVT_ASSERT(a_miss_zero, clk, arst_n, done && (status == STAT_SET_FULL || status == STAT_GET_MISS) |-> found_value == '0 && entry_index == '0, "full or miss result carries data")

	`AOKVT_ASSERT(a_single_last, clk, arst_n, done && status != STAT_WALK_ENTRY |-> last, "set or get result not marked last")

	`AOKVT_ASSERT(a_walk_back_to_back, clk, arst_n, done && !last |=> done && status == STAT_WALK_ENTRY, "walk results not on consecutive cycles")

	`AOKVT_ASSERT(a_walk_holds_busy, clk, arst_n, done && !last |-> busy && entry_count != '0, "walk in progress with block idle")

endmodule

bind append_only_key_value_table_top aokvt_chk #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);

`default_nettype wire
